// ===== rtl/clw_pkg.sv =====
package clw_pkg;

   // Field widths
   localparam int unsigned TYPE_W   = 2;
   localparam int unsigned VALUE_W  = 8;
   localparam int unsigned COL_W    = 6;
   localparam int unsigned ROW_W    = 2;
   localparam int unsigned ROWCNT_W = 3;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 6;

   // Display geometry
   localparam int unsigned MAX_ROWS = 4;
   localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET    = 3'd2;
   localparam logic [COL_W-1:0]    COLUMN_COUNT_RESET = 6'd16;

   // Queue between the front and back parts
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'd1;

   // Set-DDRAM-address command bit
   localparam logic ADDR_CMD_BIT = 1'b1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_COMMAND = 2'd0,
      REQ_CHAR    = 2'd1,
      REQ_CURSOR  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      PH_ADDR_HI = 2'd0,
      PH_ADDR_LO = 2'd1,
      PH_DATA_HI = 2'd2,
      PH_DATA_LO = 2'd3
   } phase_type;

   // One queued item: optional address byte, then the main byte
   typedef struct packed {
      logic               has_addr;
      logic [VALUE_W-1:0] addr_byte;
      logic               main_rs;
      logic [VALUE_W-1:0] main_byte;
   } entry_type;

   // DDRAM start address of each row
   function automatic logic [6:0] row_base(input logic [ROW_W-1:0] r);
      logic [6:0] b;
      unique case (r)
         2'd0: b = 7'h00;
         2'd1: b = 7'h40;
         2'd2: b = 7'h14;
         2'd3: b = 7'h54;
         default: b = 7'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/char_lcd_4bit_writer.sv =====
// Character LCD writer for a 4-bit HD44780-style bus. Each request becomes
// two or four nibble transfers on the rsp_ channel (high nibble first, with
// rsp_last on the final nibble; rsp_reg_select is high only for character
// data): a command gives its byte, a set cursor gives the address command, a
// character gives its byte, preceded by the next row's address when the
// column has reached column_count. Request code 3 is taken and produces
// nothing. The block sends one nibble per clock when rsp_stall stays low;
// requests are classified and the cursor updated in the cycle they are
// taken, and a QUEUE_DEPTH-entry queue lets new requests in while earlier
// ones are still being sent. Write row_count and column_count only while no
// transfer is pending.
module char_lcd_4bit_writer #(
   parameter int unsigned QUEUE_DEPTH = clw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [clw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [clw_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [clw_pkg::TYPE_W-1:0]      req_type,
   input  logic [clw_pkg::VALUE_W-1:0]     req_value,
   input  logic [clw_pkg::COL_W-1:0]       req_column,
   input  logic [clw_pkg::ROW_W-1:0]       req_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_reg_select,
   output logic [clw_pkg::NIBBLE_W-1:0]    rsp_nibble,
   output logic                            rsp_last
);
   import clw_pkg::*;

   logic      queue_full;
   logic      queue_empty;
   logic      queue_push;
   logic      queue_pop;
   entry_type push_entry;
   entry_type pop_entry;

   clw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_value        (req_value),
      .req_column       (req_column),
      .req_row          (req_row),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_entry      (push_entry)
   );

   clw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   clw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_entry    (pop_entry),
      .queue_pop      (queue_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== rtl/clw_front.sv =====
module clw_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [clw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [clw_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [clw_pkg::TYPE_W-1:0]      req_type,
   input  logic [clw_pkg::VALUE_W-1:0]     req_value,
   input  logic [clw_pkg::COL_W-1:0]       req_column,
   input  logic [clw_pkg::ROW_W-1:0]       req_row,
   input  logic                            queue_full,
   output logic                            queue_push,
   output clw_pkg::entry_type              queue_entry
);
   import clw_pkg::*;

   logic [ROWCNT_W-1:0] row_count_ff;
   logic [COL_W-1:0]    column_count_ff;
   logic [COL_W-1:0]    cursor_col_ff, cursor_col_in;
   logic [ROW_W-1:0]    cursor_row_ff, cursor_row_in;

   logic                accept;
   logic [ROWCNT_W-1:0] eff_rows;
   logic [ROWCNT_W-1:0] raw_row;
   logic [ROW_W-1:0]    place_row;
   logic [COL_W-1:0]    place_col;
   logic [6:0]          addr_sum;
   logic [VALUE_W-1:0]  addr_byte;
   logic                wrap;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff    <= ROW_COUNT_RESET;
         column_count_ff <= COLUMN_COUNT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ROW_COUNT) begin
            row_count_ff <= csr_write_data[ROWCNT_W-1:0];
         end
         if (csr_index == CSR_COLUMN_COUNT) begin
            column_count_ff <= csr_write_data[COL_W-1:0];
         end
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Cursor placement: clamp rows, form the address command
   always_comb begin
      eff_rows = (row_count_ff > ROWCNT_W'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS) : row_count_ff;
      wrap     = (cursor_col_ff >= column_count_ff);
      if (req_type == REQ_CURSOR) begin
         raw_row   = {1'b0, req_row};
         place_col = req_column;
      end else begin
         raw_row   = {1'b0, cursor_row_ff} + ROWCNT_W'(1);
         place_col = '0;
      end
      place_row = (raw_row >= eff_rows) ? '0 : raw_row[ROW_W-1:0];
      addr_sum  = {1'b0, place_col} + row_base(place_row);
      addr_byte = {ADDR_CMD_BIT, addr_sum};
   end

   // Classify the request and build the queue entry
   always_comb begin
      queue_push    = 1'b0;
      queue_entry   = '0;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      unique case (req_type)
         REQ_COMMAND: begin
            queue_push            = accept;
            queue_entry.main_rs   = 1'b0;
            queue_entry.main_byte = req_value;
         end
         REQ_CHAR: begin
            queue_push            = accept;
            queue_entry.has_addr  = wrap;
            queue_entry.addr_byte = addr_byte;
            queue_entry.main_rs   = 1'b1;
            queue_entry.main_byte = req_value;
            if (wrap) begin
               cursor_col_in = COL_W'(1);
               cursor_row_in = place_row;
            end else begin
               cursor_col_in = cursor_col_ff + COL_W'(1);
            end
         end
         REQ_CURSOR: begin
            queue_push            = accept;
            queue_entry.main_rs   = 1'b0;
            queue_entry.main_byte = addr_byte;
            cursor_col_in         = place_col;
            cursor_row_in         = place_row;
         end
         default: begin
            // drop unused request codes
            queue_push = 1'b0;
         end
      endcase
   end

   // Advance the cursor on each accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
      end else if (accept) begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> accept && !queue_full)
      else $error("queue push without an accepted request");

   a_cursor_row_in_range: assert property (@(posedge clock) disable iff (reset)
      accept && req_type == REQ_CURSOR && eff_rows != '0
      |=> ROWCNT_W'(cursor_row_ff) < $past(eff_rows))
      else $error("cursor row past row count after set cursor");

endmodule

// ===== rtl/clw_queue.sv =====
module clw_queue #(
   parameter int unsigned DEPTH = clw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  clw_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output clw_pkg::entry_type pop_entry,
   output logic               empty
);
   import clw_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = store_ff[rd_ptr_ff];

   // Step pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy past depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

// ===== rtl/clw_back.sv =====
module clw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             queue_empty,
   input  clw_pkg::entry_type               queue_entry,
   output logic                             queue_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_reg_select,
   output logic [clw_pkg::NIBBLE_W-1:0]     rsp_nibble,
   output logic                             rsp_last
);
   import clw_pkg::*;

   entry_type cur_ff, cur_in;
   logic      cur_valid_ff, cur_valid_in;
   phase_type phase_ff, phase_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_rs_ff, rsp_rs_in;
   logic [NIBBLE_W-1:0] rsp_nibble_ff, rsp_nibble_in;
   logic                rsp_last_ff, rsp_last_in;

   logic out_load;
   logic emit;
   logic done;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = cur_valid_ff && out_load;
   assign done      = emit && (phase_ff == PH_DATA_LO);
   assign queue_pop = !queue_empty && (!cur_valid_ff || done);

   // Next phase: start a new entry, step through nibbles, or hold
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      if (queue_pop) begin
         cur_in       = queue_entry;
         cur_valid_in = 1'b1;
         phase_in     = queue_entry.has_addr ? PH_ADDR_HI : PH_DATA_HI;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         unique case (phase_ff)
            PH_ADDR_HI: phase_in = PH_ADDR_LO;
            PH_ADDR_LO: phase_in = PH_DATA_HI;
            PH_DATA_HI: phase_in = PH_DATA_LO;
            PH_DATA_LO: phase_in = PH_DATA_LO;
            default:    phase_in = PH_DATA_LO;
         endcase
      end
   end

   // Output: pick the nibble for this phase into the result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_nibble_in = rsp_nibble_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         unique case (phase_ff)
            PH_ADDR_HI: begin
               rsp_rs_in     = 1'b0;
               rsp_nibble_in = cur_ff.addr_byte[7:4];
            end
            PH_ADDR_LO: begin
               rsp_rs_in     = 1'b0;
               rsp_nibble_in = cur_ff.addr_byte[3:0];
            end
            PH_DATA_HI: begin
               rsp_rs_in     = cur_ff.main_rs;
               rsp_nibble_in = cur_ff.main_byte[7:4];
            end
            PH_DATA_LO: begin
               rsp_rs_in     = cur_ff.main_rs;
               rsp_nibble_in = cur_ff.main_byte[3:0];
            end
            default: begin
               rsp_rs_in     = cur_ff.main_rs;
               rsp_nibble_in = cur_ff.main_byte[3:0];
            end
         endcase
         rsp_last_in = (phase_ff == PH_DATA_LO);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= PH_DATA_HI;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      rsp_rs_ff     <= rsp_rs_in;
      rsp_nibble_ff <= rsp_nibble_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_nibble     = rsp_nibble_ff;
   assign rsp_last       = rsp_last_ff;

   a_phase_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && !out_load |=> $stable(phase_ff) && cur_valid_ff)
      else $error("nibble phase moved while the output was stalled");

   a_pop_only_when_free: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !cur_valid_ff || done)
      else $error("new entry loaded over one still in progress");

endmodule
